FILE: rtl/ipv6_lpm_pkg.sv
// ----------------------------------------------------------------------------
// IPv6 LPM table package
// Request codes, status codes, the token that walks the cell chain, and the
// prefix mask helper.
// ----------------------------------------------------------------------------
package ipv6_lpm_pkg;

    localparam int          ADDR_BITS = 128;
    localparam logic [7:0]  MAX_LEN   = 8'd128;

    localparam logic [1:0]  OP_LOOKUP = 2'd0;
    localparam logic [1:0]  OP_INSERT = 2'd1;
    localparam logic [1:0]  OP_DELETE = 2'd2;

    localparam logic [2:0]  ST_LOOKUP    = 3'd0;
    localparam logic [2:0]  ST_INSERTED  = 3'd1;
    localparam logic [2:0]  ST_REPLACED  = 3'd2;
    localparam logic [2:0]  ST_FULL      = 3'd3;
    localparam logic [2:0]  ST_DELETED   = 3'd4;
    localparam logic [2:0]  ST_NOT_FOUND = 3'd5;

    typedef struct packed {
        logic        vld;
        logic        pass2;     // second walk of a new insert: claim first free slot
        logic [1:0]  op;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic [7:0]  len;
        logic [31:0] val;
        logic [7:0]  best_len;
        logic        hit;
        logic [31:0] rval;
        logic        exact;
        logic        claimed;
    } t_token;

    function automatic logic [ADDR_BITS-1:0] prefix_mask(input logic [7:0] len);
        prefix_mask = ~({ADDR_BITS{1'b1}} >> len);
    endfunction

endpackage

FILE: rtl/ipv6_lpm_req_if.sv
// ----------------------------------------------------------------------------
// IPv6 LPM request channel
// Valid/ready channel carrying one table request.
// ----------------------------------------------------------------------------
interface ipv6_lpm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [7:0]  prefix_length;
    logic [31:0] entry_value;

    modport source (output valid, op, key_high, key_low, prefix_length, entry_value,
                    input ready);
    modport sink   (input valid, op, key_high, key_low, prefix_length, entry_value,
                    output ready);
endinterface

FILE: rtl/ipv6_lpm_rsp_if.sv
// ----------------------------------------------------------------------------
// IPv6 LPM response channel
// Valid/ready channel carrying one table response.
// ----------------------------------------------------------------------------
interface ipv6_lpm_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] result_value;
    logic [2:0]  status;

    modport source (output valid, hit, result_value, status, input ready);
    modport sink   (input valid, hit, result_value, status, output ready);
endinterface

FILE: rtl/ipv6_lpm_cell.sv
// ----------------------------------------------------------------------------
// IPv6 LPM table cell
// Holds one route slot; updates the passing token and registers it for the
// next cell.
// ----------------------------------------------------------------------------
module ipv6_lpm_cell #(
    parameter int STORE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_hold,
    input  ipv6_lpm_pkg::t_token  i_tok,
    output ipv6_lpm_pkg::t_token  o_tok
);

    logic                                 r_valid;
    logic [ipv6_lpm_pkg::ADDR_BITS-1:0]   r_pfx;
    logic [7:0]                           r_len;
    logic [STORE_BITS-1:0]                r_val;
    ipv6_lpm_pkg::t_token                 r_tok;
    ipv6_lpm_pkg::t_token                 n_tok;

    logic                                 is_ins;
    logic                                 is_del;
    logic [ipv6_lpm_pkg::ADDR_BITS-1:0]   key;
    logic                                 lkp_match;
    logic                                 exact;
    logic                                 wr_val;
    logic                                 clr;
    logic                                 claim;

    always_comb begin
        is_ins    = (i_tok.op == ipv6_lpm_pkg::OP_INSERT);
        is_del    = (i_tok.op == ipv6_lpm_pkg::OP_DELETE);
        key       = {i_tok.key_hi, i_tok.key_lo};
        lkp_match = r_valid && ((key & ipv6_lpm_pkg::prefix_mask(r_len)) == r_pfx) &&
                    (!i_tok.hit || (r_len > i_tok.best_len));
        exact     = r_valid && (r_len == i_tok.len) && (r_pfx == key);
        n_tok     = i_tok;
        wr_val    = 1'b0;
        clr       = 1'b0;
        claim     = 1'b0;
        if (i_tok.vld) begin
            if (!is_ins && !is_del) begin
                if (lkp_match) begin
                    n_tok.hit      = 1'b1;
                    n_tok.best_len = r_len;
                    n_tok.rval     = 32'(r_val);
                end
            end else if (!i_tok.pass2) begin
                if (exact) begin
                    n_tok.exact = 1'b1;
                    if (is_del) begin
                        clr        = 1'b1;
                        n_tok.hit  = 1'b1;
                        n_tok.rval = 32'(r_val);
                    end else begin
                        wr_val = 1'b1;
                    end
                end
            end else if (!i_tok.claimed && !r_valid) begin
                claim         = 1'b1;
                n_tok.claimed = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (claim) begin
            r_valid <= 1'b1;
        end else if (clr) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (claim) begin
            r_pfx <= key;
            r_len <= i_tok.len;
            r_val <= i_tok.val[STORE_BITS-1:0];
        end else if (wr_val) begin
            r_val <= i_tok.val[STORE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else if (!i_hold) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: rtl/ipv6_longest_prefix_match_table_unit.sv
// ----------------------------------------------------------------------------
// IPv6 longest prefix match table
// Route table built as a chain of slot cells; one request walks the chain.
// ----------------------------------------------------------------------------
// Each request is registered at the entry, walks the TABLE_ENTRIES cell
// registers and has its result registered for the response; a new insert
// walks the chain twice, the second time to claim the first free slot. One
// request in the chain at a time: none is taken until the response is
// registered. Reset clears every slot's valid bit; no clearing pass.
module ipv6_longest_prefix_match_table_unit #(
    parameter int TABLE_ENTRIES = 64,
    parameter int VALUE_BITS    = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ipv6_lpm_req_if.sink          i_req,
    ipv6_lpm_rsp_if.source        o_rsp
);

    localparam int STORE_BITS = (VALUE_BITS < 32) ? VALUE_BITS : 32;

    ipv6_lpm_pkg::t_token  w_tok [TABLE_ENTRIES+1];
    ipv6_lpm_pkg::t_token  r_entry;
    ipv6_lpm_pkg::t_token  n_entry;
    ipv6_lpm_pkg::t_token  e;

    logic                  r_busy;
    logic                  r_out_vld;
    logic                  r_out_hit;
    logic [31:0]           r_out_val;
    logic [2:0]            r_out_st;

    logic                  accept;
    logic                  end_recirc;
    logic                  end_done;
    logic                  out_free;
    logic                  hold;
    logic [7:0]            len_sat;
    logic [2:0]            end_st;
    logic [ipv6_lpm_pkg::ADDR_BITS-1:0] key_in;

    assign i_req.ready = !r_busy;
    assign accept      = i_req.valid && !r_busy;

    assign e          = w_tok[TABLE_ENTRIES];
    assign end_recirc = e.vld && (e.op == ipv6_lpm_pkg::OP_INSERT) && !e.pass2 && !e.exact;
    assign end_done   = e.vld && !end_recirc;
    assign out_free   = !r_out_vld || o_rsp.ready;
    assign hold       = end_done && !out_free;

    always_comb begin
        len_sat = (i_req.prefix_length > ipv6_lpm_pkg::MAX_LEN) ?
                  ipv6_lpm_pkg::MAX_LEN : i_req.prefix_length;
        key_in  = {i_req.key_high, i_req.key_low};
        if ((i_req.op == ipv6_lpm_pkg::OP_INSERT) || (i_req.op == ipv6_lpm_pkg::OP_DELETE)) begin
            key_in = key_in & ipv6_lpm_pkg::prefix_mask(len_sat);
        end
        n_entry     = e;
        n_entry.vld = 1'b0;
        if (accept) begin
            n_entry.vld      = 1'b1;
            n_entry.pass2    = 1'b0;
            n_entry.op       = i_req.op;
            n_entry.key_hi   = key_in[127:64];
            n_entry.key_lo   = key_in[63:0];
            n_entry.len      = len_sat;
            n_entry.val      = i_req.entry_value;
            n_entry.best_len = 8'd0;
            n_entry.hit      = 1'b0;
            n_entry.rval     = 32'd0;
            n_entry.exact    = 1'b0;
            n_entry.claimed  = 1'b0;
        end else if (end_recirc) begin
            n_entry.vld   = 1'b1;
            n_entry.pass2 = 1'b1;
        end
    end

    always_comb begin
        case (e.op)
            ipv6_lpm_pkg::OP_INSERT: begin
                if (e.pass2) begin
                    end_st = e.claimed ? ipv6_lpm_pkg::ST_INSERTED : ipv6_lpm_pkg::ST_FULL;
                end else begin
                    end_st = ipv6_lpm_pkg::ST_REPLACED;
                end
            end
            ipv6_lpm_pkg::OP_DELETE: begin
                end_st = e.exact ? ipv6_lpm_pkg::ST_DELETED : ipv6_lpm_pkg::ST_NOT_FOUND;
            end
            default: begin
                end_st = ipv6_lpm_pkg::ST_LOOKUP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.vld <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign w_tok[0] = r_entry;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        ipv6_lpm_cell #(
            .STORE_BITS (STORE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_hold  (hold),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (end_done && out_free) begin
                r_busy <= 1'b0;
            end
            if (end_done && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (end_done && out_free) begin
            r_out_hit <= e.hit;
            r_out_val <= e.rval;
            r_out_st  <= end_st;
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.hit          = r_out_hit;
    assign o_rsp.result_value = r_out_val;
    assign o_rsp.status       = r_out_st;

endmodule

FILE: rtl/ipv6_lpm_checker.sv
// ----------------------------------------------------------------------------
// IPv6 LPM port checker
// Port-level properties of the table unit, bound to the top level.
// ----------------------------------------------------------------------------
module ipv6_lpm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic        i_rsp_hit,
    input logic [31:0] i_rsp_value,
    input logic [2:0]  i_rsp_status
);

    // one request in flight: accept closes the request channel
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while another is in flight");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
        (i_rsp_valid && $stable(i_rsp_hit) && $stable(i_rsp_value) && $stable(i_rsp_status)))
        else $error("stalled response changed");

    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_hit) |->
        ((i_rsp_status == ipv6_lpm_pkg::ST_LOOKUP) || (i_rsp_status == ipv6_lpm_pkg::ST_DELETED)))
        else $error("hit with wrong status");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_hit) |-> (i_rsp_value == 32'd0))
        else $error("nonzero value without hit");

    a_deleted_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status == ipv6_lpm_pkg::ST_DELETED)) |-> i_rsp_hit)
        else $error("deleted without hit");

endmodule

bind ipv6_longest_prefix_match_table_unit ipv6_lpm_checker u_ipv6_lpm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_hit    (o_rsp.hit),
    .i_rsp_value  (o_rsp.result_value),
    .i_rsp_status (o_rsp.status)
);
